>>> src/lpfr_pkg.sv
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared constants and controller/datapath interface types for the LRU
// page frame replacer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfr_pkg;

  // Frame table geometry
  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;

  // Fixed port widths
  localparam int PAGE_IN_W  = 16;
  localparam int SLOT_OUT_W = 3;
  localparam int CFG_W      = 4;
  localparam int TOTAL_W    = 32;

  // Derived widths
  localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_W  = FRAME_W;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  // Oldest rank a frame can reach
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);

  // Frame count after reset
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(8);

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture input word
    logic eval;    // lookup and pick frame
    logic commit;  // update frames, counters and result register
  } lpfr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // result register can take a new word this cycle
  } lpfr_status_t;

endpackage

`default_nettype wire

>>> src/lru_page_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// lru_page_frame_replacer_core
// LRU page frame replacer: one page reference in, one placement word out.
// ----------------------------------------------------------------------------
// Each accepted reference is looked up in frames 0..frames_in_use-1 (a
// written value of 0 acts as 1, values above 8 act as 8; reset value 8).
// A hit reports its frame; a miss fills the lowest empty frame or evicts the
// least recently used one and reports the evicted page. Hit and fault totals
// saturate at 2^32-1. Each item passes through capture, a lookup step that
// compares all frames and picks the victim, and a commit step that updates
// the frame table and loads the result register. The commit waits while the
// result register is full and stalled; after commit the next reference is
// taken in the following cycle. Write frames_in_use only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_frame_replacer_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [lpfr_pkg::CFG_W-1:0]      frames_in_use_i,
  // reference input
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire [lpfr_pkg::PAGE_IN_W-1:0]  page_number_i,
  // result output
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic                           hit_o,
  output logic [lpfr_pkg::SLOT_OUT_W-1:0] frame_slot_o,
  output logic                           evicted_valid_o,
  output logic [lpfr_pkg::PAGE_IN_W-1:0] evicted_page_o,
  output logic [lpfr_pkg::TOTAL_W-1:0]   hit_total_o,
  output logic [lpfr_pkg::TOTAL_W-1:0]   fault_total_o
);
  import lpfr_pkg::*;

  lpfr_cmd_t    cmd;
  lpfr_status_t status;

  // Config register always writable
  assign cfg_ready_o = 1'b1;

  lpfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lpfr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_valid_i),
    .frames_in_use_i (frames_in_use_i),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .frame_slot_o    (frame_slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .hit_total_o     (hit_total_o),
    .fault_total_o   (fault_total_o)
  );

endmodule

`default_nettype wire

>>> src/lpfr_ctrl.sv
// ----------------------------------------------------------------------------
// lpfr_ctrl
// Sequencer: accept a reference, evaluate it, then commit once the result
// register has room.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  lpfr_pkg::lpfr_status_t status_i,
  output lpfr_pkg::lpfr_cmd_t    cmd_o
);
  import lpfr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    stall_d     = stall_q;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          stall_d    = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_COMMIT;
      end
      S_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          stall_d      = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        stall_d = 1'b0;
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;

endmodule

`default_nettype wire

>>> src/lpfr_datapath.sv
// ----------------------------------------------------------------------------
// lpfr_datapath
// Frame table, parallel page compare, LRU victim pick, rank aging,
// saturating totals and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_datapath (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  lpfr_pkg::lpfr_cmd_t          cmd_i,
  output lpfr_pkg::lpfr_status_t       status_o,
  input  wire                         cfg_valid_i,
  input  wire [lpfr_pkg::CFG_W-1:0]   frames_in_use_i,
  input  wire [lpfr_pkg::PAGE_IN_W-1:0] page_number_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic                        hit_o,
  output logic [lpfr_pkg::SLOT_OUT_W-1:0] frame_slot_o,
  output logic                        evicted_valid_o,
  output logic [lpfr_pkg::PAGE_IN_W-1:0]  evicted_page_o,
  output logic [lpfr_pkg::TOTAL_W-1:0]    hit_total_o,
  output logic [lpfr_pkg::TOTAL_W-1:0]    fault_total_o
);
  import lpfr_pkg::*;

  // Configuration
  logic [CFG_W-1:0] frames_cfg_q;

  // Frame table
  logic [PAGE_BITS-1:0] frame_page_q [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid_q;
  logic [RANK_W-1:0]    rank_q [MAX_FRAMES];

  // Captured reference
  logic [PAGE_BITS-1:0] page_q;

  // Decision registers
  logic                  dec_hit_q;
  logic                  dec_evict_q;
  logic [FRAME_W-1:0]    dec_slot_q;
  logic [RANK_W-1:0]     dec_old_rank_q;
  logic [MAX_FRAMES-1:0] dec_active_q;

  // Totals
  logic [TOTAL_W-1:0] hit_cnt_q, hit_cnt_d;
  logic [TOTAL_W-1:0] fault_cnt_q, fault_cnt_d;

  // Result register
  logic                  out_valid_q;
  logic                  res_hit_q;
  logic [SLOT_OUT_W-1:0] res_slot_q;
  logic                  res_evict_q;
  logic [PAGE_IN_W-1:0]  res_page_q;

  // Evaluation signals
  logic [CMP_W-1:0]      count;
  logic [MAX_FRAMES-1:0] active;
  logic [MAX_FRAMES-1:0] match;
  logic [MAX_FRAMES-1:0] empty;
  logic [FRAME_W-1:0]    hit_slot, empty_slot, victim_slot, pick_slot;
  logic [RANK_W-1:0]     best_rank;
  logic                  any_hit, any_empty;

  // Clamp configured frame count to 1..MAX_FRAMES
  always_comb begin
    if (CMP_W'(frames_cfg_q) == '0) begin
      count = CMP_W'(1);
    end else if (CMP_W'(frames_cfg_q) > CMP_W'(MAX_FRAMES)) begin
      count = CMP_W'(MAX_FRAMES);
    end else begin
      count = CMP_W'(frames_cfg_q);
    end
  end

  // Per-frame compare
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      active[i] = CMP_W'(i) < count;
      match[i]  = active[i] && frame_valid_q[i] && (frame_page_q[i] == page_q);
      empty[i]  = active[i] && !frame_valid_q[i];
    end
  end

  assign any_hit   = |match;
  assign any_empty = |empty;

  // Lowest-numbered hit and lowest-numbered empty frame
  always_comb begin
    hit_slot   = '0;
    empty_slot = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = FRAME_W'(i);
      end
      if (empty[i]) begin
        empty_slot = FRAME_W'(i);
      end
    end
  end

  // Oldest frame, lowest number wins ties
  always_comb begin
    best_rank   = '0;
    victim_slot = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (active[i] && (rank_q[i] > best_rank)) begin
        best_rank   = rank_q[i];
        victim_slot = FRAME_W'(i);
      end
    end
  end

  assign pick_slot = any_hit ? hit_slot : (any_empty ? empty_slot : victim_slot);

  // Saturating totals
  always_comb begin
    hit_cnt_d   = hit_cnt_q;
    fault_cnt_d = fault_cnt_q;
    if (dec_hit_q) begin
      if (hit_cnt_q != '1) begin
        hit_cnt_d = hit_cnt_q + TOTAL_W'(1);
      end
    end else begin
      if (fault_cnt_q != '1) begin
        fault_cnt_d = fault_cnt_q + TOTAL_W'(1);
      end
    end
  end

  // Config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_cfg_q <= FRAMES_RESET;
    end else if (cfg_valid_i) begin
      frames_cfg_q <= frames_in_use_i;
    end
  end

  // Input capture and decision registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q <= PAGE_BITS'(page_number_i);
    end
    if (cmd_i.eval) begin
      dec_hit_q      <= any_hit;
      dec_evict_q    <= !any_hit && !any_empty;
      dec_slot_q     <= pick_slot;
      dec_old_rank_q <= rank_q[pick_slot];
      dec_active_q   <= active;
    end
  end

  // Page store, written only on a fault
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !dec_hit_q) begin
      frame_page_q[dec_slot_q] <= page_q;
    end
  end

  // Valid marks, ranks and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_valid_q <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_q[i] <= '0;
      end
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
    end else if (cmd_i.commit) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (FRAME_W'(i) == dec_slot_q) begin
          rank_q[i] <= '0;
        end else if (dec_active_q[i] && frame_valid_q[i] &&
                     (!(dec_hit_q || dec_evict_q) || (rank_q[i] < dec_old_rank_q)) &&
                     (rank_q[i] != RANK_MAX)) begin
          rank_q[i] <= rank_q[i] + RANK_W'(1);
        end
      end
      frame_valid_q[dec_slot_q] <= 1'b1;
      hit_cnt_q   <= hit_cnt_d;
      fault_cnt_q <= fault_cnt_d;
    end
  end

  // Result register handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_hit_q   <= dec_hit_q;
      res_slot_q  <= SLOT_OUT_W'(dec_slot_q);
      res_evict_q <= dec_evict_q;
      res_page_q  <= dec_evict_q ? PAGE_IN_W'(frame_page_q[dec_slot_q]) : '0;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign hit_o           = res_hit_q;
  assign frame_slot_o    = res_slot_q;
  assign evicted_valid_o = res_evict_q;
  assign evicted_page_o  = res_page_q;
  assign hit_total_o     = hit_cnt_q;
  assign fault_total_o   = fault_cnt_q;

endmodule

`default_nettype wire

>>> src/lpfr_checker.sv
// ----------------------------------------------------------------------------
// lpfr_checker
// Port-level checks for the LRU page frame replacer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire        hit_o,
  input wire        evicted_valid_o,
  input wire [15:0] evicted_page_o,
  input wire [31:0] hit_total_o,
  input wire [31:0] fault_total_o
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_valid_o))
    else $error("hit reported together with eviction");

  // No eviction means a zero evicted page
  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> evicted_page_o == 16'd0)
    else $error("evicted page nonzero without eviction");

  // The total matching the outcome has counted it
  a_total_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o ? (hit_total_o != 32'd0) : (fault_total_o != 32'd0)))
    else $error("total not advanced for reported outcome");

endmodule

bind lru_page_frame_replacer_core lpfr_checker u_lpfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .hit_o           (hit_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o),
  .hit_total_o     (hit_total_o),
  .fault_total_o   (fault_total_o)
);

`default_nettype wire
